// File: sv/linear_congruence_crt_combiner_assert.svh
// assertion macros for the congruence combiner
`ifndef LINEAR_CONGRUENCE_CRT_COMBINER_ASSERT_SVH
`define LINEAR_CONGRUENCE_CRT_COMBINER_ASSERT_SVH

// same-cycle implication
`define LCC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("lcc assertion failed");

// next-cycle implication
`define LCC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lcc assertion failed");

`endif

// File: sv/lcc_pkg.sv
`default_nettype none
package lcc_pkg;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } lcc_req_t;

  localparam int ANS_W     = 63;
  localparam int OUT_DW    = 64;
  localparam int FLAG_W    = 2;
  localparam int FLAG_NOSOL = 0;
  localparam int FLAG_OVF   = 1;

endpackage
`default_nettype wire

// File: sv/lcc_unit.sv
`default_nettype none
// shared shift-add multiplier / restoring divider, one bit per cycle
module lcc_unit #(
  parameter int IB = 31,
  parameter int AW = 63,
  parameter int XW = 63
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lcc_pkg::lcc_req_t   req_i,
  input  wire  [XW-1:0]       a_i,
  input  wire  [IB-1:0]       b_i,
  output logic                done_o,
  output logic [XW-1:0]       quo_o,
  output logic [IB-1:0]       rem_o,
  output logic [AW+IB-1:0]    prod_o
);
  import lcc_pkg::*;

  localparam int PW  = AW + IB;
  localparam int CNW = $clog2(XW);

  logic           busy_q, done_q;
  op_e            op_q;
  logic [CNW-1:0] cnt_q;
  logic [XW-1:0]  sh_q, sh_d;
  logic [IB-1:0]  rem_q, rem_d, dvs_q;
  logic [AW-1:0]  mcand_q;
  logic [PW-1:0]  acc_q, acc_d;
  logic [IB:0]    trial;
  logic           ge;

  always_comb begin
    trial = {rem_q, sh_q[XW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? IB'(trial - {1'b0, dvs_q}) : trial[IB-1:0];
    sh_d  = (op_q == OP_DIV) ? {sh_q[XW-2:0], ge} : {sh_q[XW-2:0], 1'b0};
    acc_d = {acc_q[PW-2:0], 1'b0} + (sh_q[XW-1] ? PW'(mcand_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      op_q    <= OP_MUL;
      cnt_q   <= '0;
      sh_q    <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      mcand_q <= '0;
      acc_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        op_q    <= req_i.op;
        sh_q    <= (req_i.op == OP_DIV) ? a_i : {b_i, {(XW-IB){1'b0}}};
        mcand_q <= a_i[AW-1:0];
        dvs_q   <= b_i;
        rem_q   <= '0;
        acc_q   <= '0;
        cnt_q   <= (req_i.op == OP_DIV) ? CNW'(XW-1) : CNW'(IB-1);
      end else if (busy_q) begin
        sh_q <= sh_d;
        if (op_q == OP_DIV) begin
          rem_q <= rem_d;
        end else begin
          acc_q <= acc_d;
        end
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
  assign rem_o  = rem_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// File: sv/linear_congruence_crt_combiner.sv
`default_nettype none
// channel  dir  fields (tdata low bit up / tuser / tlast)
// s_axis   in   speed, track_length, offset / first_item / last_item
// m_axis   out  answer / no_solution, overflow / -
//
// One beat in, then s_axis_tready stays low until the item is merged.
// Each divide and each multiply runs on the one shared unit; two extended
// Euclid runs of up to about 1.44*INPUT_BITS steps (one divide and one multiply
// each) dominate the work per item, with far less work after an error.
// Reset clears the running pair to residue 0, modulus 1. A stalled result
// holds the block in its final step until taken.
module linear_congruence_crt_combiner #(
  parameter int INPUT_BITS   = 31,
  parameter int MODULUS_BITS = 63
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // speed, track_length, offset
  input  wire  [((3*INPUT_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // first_item
  input  wire  [0:0]                       s_axis_tuser_i,
  input  wire                              s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // answer
  output logic [lcc_pkg::OUT_DW-1:0]       m_axis_tdata_o,
  // no_solution, overflow
  output logic [lcc_pkg::FLAG_W-1:0]       m_axis_tuser_o
);
  import lcc_pkg::*;

  localparam int IB = INPUT_BITS;
  localparam int MB = MODULUS_BITS;
  localparam int AW = (MB > IB) ? MB : IB;
  localparam int XW = (MB > 2*IB) ? MB : 2*IB;
  localparam int PW = AW + IB;
  localparam int CW = IB + 2;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SMOD = 5'd1;
  localparam logic [4:0] ST_OMOD = 5'd2;
  localparam logic [4:0] ST_EDIV = 5'd3;
  localparam logic [4:0] ST_EMUL = 5'd4;
  localparam logic [4:0] ST_OCHK = 5'd5;
  localparam logic [4:0] ST_MDIV = 5'd6;
  localparam logic [4:0] ST_NEED = 5'd7;
  localparam logic [4:0] ST_INV  = 5'd8;
  localparam logic [4:0] ST_RMUL = 5'd9;
  localparam logic [4:0] ST_RMOD = 5'd10;
  localparam logic [4:0] ST_RRES = 5'd11;
  localparam logic [4:0] ST_AMOD = 5'd12;
  localparam logic [4:0] ST_MPD  = 5'd13;
  localparam logic [4:0] ST_DCHK = 5'd14;
  localparam logic [4:0] ST_NMUL = 5'd15;
  localparam logic [4:0] ST_KMUL = 5'd16;
  localparam logic [4:0] ST_KMOD = 5'd17;
  localparam logic [4:0] ST_UPD  = 5'd18;
  localparam logic [4:0] ST_DONE = 5'd19;

  logic [4:0]   state_q;
  logic         wait_q, pass_q, last_q;
  logic [IB-1:0] spd_q, len_q, off_q, o_q, r0_q, r1_q, q_q, g_q, g2_q;
  logic [IB-1:0] m_q, mp_q, need_q, inv_q, r_q, rm_q, dq_q, k_q;
  logic signed [CW-1:0] c0_q, c1_q, x_q;
  logic [MB-1:0] res_q, mod_q, nm_q;
  logic [FLAG_W-1:0] flags_q;

  logic          ov_q;
  logic [ANS_W-1:0] ans_q;
  logic [FLAG_W-1:0] oflags_q;

  lcc_req_t      req;
  logic [XW-1:0] u_a;
  logic [IB-1:0] u_b;
  logic          u_done;
  logic [XW-1:0] u_quo;
  logic [IB-1:0] u_rem;
  logic [PW-1:0] u_prod;

  logic [CW-1:0] absc1, absx;
  logic [CW-1:0] pcw;
  logic [IB-1:0] nd, diff, invm, inv_fix;
  logic          issue;

  lcc_unit #(.IB(IB), .AW(AW), .XW(XW)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (u_a),
    .b_i    (u_b),
    .done_o (u_done),
    .quo_o  (u_quo),
    .rem_o  (u_rem),
    .prod_o (u_prod)
  );

  always_comb begin
    absc1   = c1_q[CW-1] ? CW'(-c1_q) : CW'(c1_q);
    absx    = x_q[CW-1] ? CW'(-x_q) : CW'(x_q);
    pcw     = u_prod[CW-1:0];
    nd      = (o_q == '0) ? '0 : len_q - o_q;
    diff    = (r_q >= rm_q) ? r_q - rm_q : IB'(r_q + m_q - rm_q);
    invm    = pass_q ? mp_q : m_q;
    inv_fix = (x_q[CW-1] && u_rem != '0) ? invm - u_rem : u_rem;
    issue   = (state_q != ST_IDLE) && (state_q != ST_DONE) && !wait_q &&
              !(state_q == ST_EDIV && r1_q == '0);
    req.start = issue;
    req.op    = OP_DIV;
    u_a       = '0;
    u_b       = '0;
    unique case (state_q)
      ST_SMOD: begin u_a = XW'(spd_q); u_b = len_q; end
      ST_OMOD: begin u_a = XW'(off_q); u_b = len_q; end
      ST_EDIV: begin u_a = XW'(r0_q);  u_b = r1_q; end
      ST_EMUL: begin req.op = OP_MUL; u_a = XW'(q_q); u_b = IB'(absc1); end
      ST_OCHK: begin u_a = XW'(o_q);   u_b = g_q; end
      ST_MDIV: begin u_a = XW'(len_q); u_b = g_q; end
      ST_NEED: begin u_a = XW'(nd);    u_b = g_q; end
      ST_INV:  begin u_a = XW'(IB'(absx)); u_b = invm; end
      ST_RMUL: begin req.op = OP_MUL; u_a = XW'(need_q); u_b = inv_q; end
      ST_RMOD: begin u_a = XW'(u_prod); u_b = m_q; end
      ST_RRES: begin u_a = XW'(res_q); u_b = m_q; end
      ST_AMOD: begin u_a = XW'(mod_q); u_b = m_q; end
      ST_MPD:  begin u_a = XW'(m_q);   u_b = g2_q; end
      ST_DCHK: begin u_a = XW'(diff);  u_b = g2_q; end
      ST_NMUL: begin req.op = OP_MUL; u_a = XW'(mod_q); u_b = mp_q; end
      ST_KMUL: begin req.op = OP_MUL; u_a = XW'(dq_q); u_b = inv_q; end
      ST_KMOD: begin u_a = XW'(u_prod); u_b = mp_q; end
      ST_UPD:  begin req.op = OP_MUL; u_a = XW'(mod_q); u_b = k_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wait_q   <= 1'b0;
      pass_q   <= 1'b0;
      last_q   <= 1'b0;
      res_q    <= '0;
      mod_q    <= MB'(1);
      flags_q  <= '0;
      ov_q     <= 1'b0;
      ans_q    <= '0;
      oflags_q <= '0;
      spd_q <= '0; len_q <= '0; off_q <= '0; o_q <= '0; r0_q <= '0; r1_q <= '0;
      q_q <= '0; g_q <= '0; g2_q <= '0; m_q <= '0; mp_q <= '0; need_q <= '0;
      inv_q <= '0; r_q <= '0; rm_q <= '0; dq_q <= '0; k_q <= '0;
      c0_q <= '0; c1_q <= '0; x_q <= '0; nm_q <= '0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      if (issue) begin
        wait_q <= 1'b1;
      end else if (u_done) begin
        wait_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            spd_q  <= s_axis_tdata_i[IB-1:0];
            len_q  <= s_axis_tdata_i[2*IB-1:IB];
            off_q  <= s_axis_tdata_i[3*IB-1:2*IB];
            last_q <= s_axis_tlast_i;
            pass_q <= 1'b0;
            if (s_axis_tuser_i[0]) begin
              res_q   <= '0;
              mod_q   <= MB'(1);
              flags_q <= '0;
            end
            if (!s_axis_tuser_i[0] && flags_q != '0) begin
              state_q <= ST_DONE;
            end else if (s_axis_tdata_i[2*IB-1:IB] == '0) begin
              flags_q[FLAG_NOSOL] <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SMOD;
            end
          end
        end
        ST_SMOD: if (u_done) begin
          r0_q <= u_rem; r1_q <= len_q; c0_q <= CW'(1); c1_q <= '0;
          state_q <= ST_OMOD;
        end
        ST_OMOD: if (u_done) begin
          o_q <= u_rem; state_q <= ST_EDIV;
        end
        ST_EDIV: begin
          if (r1_q == '0) begin
            x_q <= c0_q;
            if (!pass_q) begin
              g_q <= r0_q; state_q <= ST_OCHK;
            end else begin
              g2_q <= r0_q; state_q <= ST_MPD;
            end
          end else if (u_done) begin
            q_q <= u_quo[IB-1:0]; r0_q <= r1_q; r1_q <= u_rem;
            state_q <= ST_EMUL;
          end
        end
        ST_EMUL: if (u_done) begin
          c0_q <= c1_q;
          c1_q <= c1_q[CW-1] ? c0_q + $signed(pcw) : c0_q - $signed(pcw);
          state_q <= ST_EDIV;
        end
        ST_OCHK: if (u_done) begin
          if (u_rem != '0) begin
            flags_q[FLAG_NOSOL] <= 1'b1; state_q <= ST_DONE;
          end else begin
            state_q <= ST_MDIV;
          end
        end
        ST_MDIV: if (u_done) begin
          m_q <= u_quo[IB-1:0]; state_q <= ST_NEED;
        end
        ST_NEED: if (u_done) begin
          need_q <= u_quo[IB-1:0]; state_q <= ST_INV;
        end
        ST_INV: if (u_done) begin
          inv_q   <= inv_fix;
          state_q <= pass_q ? ST_KMUL : ST_RMUL;
        end
        ST_RMUL: if (u_done) state_q <= ST_RMOD;
        ST_RMOD: if (u_done) begin
          r_q <= u_rem; state_q <= ST_RRES;
        end
        ST_RRES: if (u_done) begin
          rm_q <= u_rem; state_q <= ST_AMOD;
        end
        ST_AMOD: if (u_done) begin
          r0_q <= u_rem; r1_q <= m_q; c0_q <= CW'(1); c1_q <= '0; pass_q <= 1'b1;
          state_q <= ST_EDIV;
        end
        ST_MPD: if (u_done) begin
          mp_q <= u_quo[IB-1:0]; state_q <= ST_DCHK;
        end
        ST_DCHK: if (u_done) begin
          if (u_rem != '0) begin
            flags_q[FLAG_NOSOL] <= 1'b1; state_q <= ST_DONE;
          end else begin
            dq_q <= u_quo[IB-1:0]; state_q <= ST_NMUL;
          end
        end
        ST_NMUL: if (u_done) begin
          if (u_prod[PW-1:MB] != '0) begin
            flags_q[FLAG_OVF] <= 1'b1; state_q <= ST_DONE;
          end else begin
            nm_q <= u_prod[MB-1:0]; state_q <= ST_INV;
          end
        end
        ST_KMUL: if (u_done) state_q <= ST_KMOD;
        ST_KMOD: if (u_done) begin
          k_q <= u_rem; state_q <= ST_UPD;
        end
        ST_UPD: if (u_done) begin
          res_q   <= res_q + u_prod[MB-1:0];
          mod_q   <= nm_q;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (!ov_q || m_axis_tready_i) begin
            ov_q     <= 1'b1;
            oflags_q <= flags_q;
            if (flags_q != '0) begin
              ans_q <= '0;
            end else begin
              ans_q <= (res_q == '0) ? ANS_W'(mod_q) : ANS_W'(res_q);
            end
            res_q   <= '0;
            mod_q   <= MB'(1);
            flags_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = OUT_DW'(ans_q);
  assign m_axis_tuser_o  = oflags_q;

endmodule
`default_nettype wire

// File: sv/lcc_checker.sv
`default_nettype none
`include "linear_congruence_crt_combiner_assert.svh"
module lcc_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid_i,
  input wire                          s_axis_tready_o,
  input wire                          m_axis_tvalid_o,
  input wire                          m_axis_tready_i,
  input wire [lcc_pkg::OUT_DW-1:0]    m_axis_tdata_o,
  input wire [lcc_pkg::FLAG_W-1:0]    m_axis_tuser_o
);
  import lcc_pkg::*;

  `LCC_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                  m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `LCC_ASSERT_NXT(a_busy_after_in, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `LCC_ASSERT_IMP(a_err_zero, m_axis_tvalid_o && m_axis_tuser_o != '0, m_axis_tdata_o == '0)
  `LCC_ASSERT_IMP(a_one_flag, m_axis_tvalid_o,
                  !(m_axis_tuser_o[FLAG_NOSOL] && m_axis_tuser_o[FLAG_OVF]))

endmodule

bind linear_congruence_crt_combiner lcc_checker u_lcc_checker (.*);
`default_nettype wire
